// ===== hw/rtl/cdq_pkg.sv =====
// Shared types and codes for the circular deque with search.
`default_nettype none

package cdq_pkg;

   // Action codes as they arrive on the request channel
   localparam logic [2:0] ACT_INSERT_FRONT = 3'd0;
   localparam logic [2:0] ACT_INSERT_BACK  = 3'd1;
   localparam logic [2:0] ACT_REMOVE_FRONT = 3'd2;
   localparam logic [2:0] ACT_REMOVE_BACK  = 3'd3;
   localparam logic [2:0] ACT_SEARCH       = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QFILL_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_SEARCH
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
   } cmd_type;

   typedef struct packed {
      logic [31:0] value;
      logic [3:0]  position;
      status_type  status;
      logic [4:0]  occupancy;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cdq_front.sv =====
// Request decode and the short command queue feeding the execution side.
`default_nettype none

module cdq_front import cdq_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_value,
   output logic             cmd_valid,
   input  wire logic        cmd_take,
   output cmd_type          cmd
);

   cmd_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff;
   logic [QPTR_BITS-1:0]  rd_ptr_ff;
   logic [QFILL_BITS-1:0] fill_ff;
   logic                  push;
   logic                  pop;
   op_type                op_dec;

   function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
      ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      case (req_action)
         ACT_INSERT_FRONT: op_dec = OP_PUSH_FRONT;
         ACT_INSERT_BACK:  op_dec = OP_PUSH_BACK;
         ACT_REMOVE_FRONT: op_dec = OP_POP_FRONT;
         ACT_REMOVE_BACK:  op_dec = OP_POP_BACK;
         ACT_SEARCH:       op_dec = OP_SEARCH;
         default:          op_dec = OP_NONE;
      endcase
   end

   assign req_stall = (fill_ff == QFILL_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_take && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{op: op_dec, value: req_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_BITS'(QUEUE_DEPTH))
      else $error("command queue overfilled");

endmodule

`default_nettype wire

// ===== hw/rtl/cdq_back.sv =====
// Execution side: ring store, front/count tracking, search walk, result register.
`default_nettype none

module cdq_back import cdq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   output logic      cmd_take,
   input  wire cmd_type cmd,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN
   } state_type;

   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rdata_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic [IW-1:0]         front_ff;
   logic [CW-1:0]         count_ff;
   logic [IW-1:0]         rd_slot_ff;
   logic [IW-1:0]         cmp_off_ff;
   state_type             state_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  slot_free;
   logic                  is_full;
   logic                  is_empty;
   logic [IW-1:0]         front_dec;
   logic [IW-1:0]         front_inc;
   logic [IW-1:0]         back_slot;
   logic [IW-1:0]         last_slot;
   logic [IW-1:0]         next_slot;
   logic                  mem_we;
   logic [IW-1:0]         mem_wa;
   logic [IW-1:0]         mem_ra;
   logic [VALUE_BITS-1:0] wr_value;
   logic [63:0]           rd_ext;

   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                              input logic [IW-1:0] off);
      logic [IW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IW+1)'(DEPTH)) begin
         sum = sum - (IW+1)'(DEPTH);
      end
      wrap_add = sum[IW-1:0];
   endfunction

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
      wrap_inc = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      cmd_take  = (state_ff == S_IDLE) && cmd_valid && slot_free;
      is_full   = (count_ff == CW'(DEPTH));
      is_empty  = (count_ff == '0);
      front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - 1'b1;
      front_inc = wrap_inc(front_ff);
      back_slot = wrap_add(front_ff, count_ff[IW-1:0]);
      last_slot = wrap_add(front_ff, IW'(count_ff - 1'b1));
      next_slot = wrap_inc(rd_slot_ff);
      wr_value  = VALUE_BITS'(cmd.value);
      // stored words are sign-extended from their top bit, then cut to the field
      rd_ext    = 64'(signed'(rdata_ff));

      mem_we = 1'b0;
      mem_wa = front_dec;
      mem_ra = front_ff;
      if (cmd_take) begin
         case (cmd.op)
            OP_PUSH_FRONT: mem_we = !is_full;
            OP_PUSH_BACK: begin
               mem_we = !is_full;
               mem_wa = back_slot;
            end
            OP_POP_BACK: mem_ra = last_slot;
            default:     mem_ra = front_ff;
         endcase
      end else if (state_ff == S_SCAN) begin
         mem_ra = next_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= wr_value;
      end
      rdata_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         front_ff     <= '0;
         count_ff     <= '0;
      end else begin
         // a take implies the held beat leaves now; the take branches set valid themselves
         if (rsp_valid_ff && !rsp_stall && !cmd_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_take) begin
                  case (cmd.op)
                     OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        rsp_valid_ff <= 1'b1;
                        if (is_full) begin
                           rsp_ff <= '{value: '0, position: '0, status: ST_FULL,
                                       occupancy: 5'(count_ff)};
                        end else begin
                           if (cmd.op == OP_PUSH_FRONT) begin
                              front_ff <= front_dec;
                           end
                           count_ff <= count_ff + 1'b1;
                           rsp_ff   <= '{value: '0, position: '0, status: ST_OK,
                                         occupancy: 5'(count_ff + 1'b1)};
                        end
                     end
                     OP_POP_FRONT, OP_POP_BACK: begin
                        if (is_empty) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff <= '{value: '0, position: '0, status: ST_EMPTY,
                                       occupancy: 5'(count_ff)};
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           if (cmd.op == OP_POP_FRONT) begin
                              front_ff <= front_inc;
                           end
                           count_ff <= count_ff - 1'b1;
                           state_ff <= S_READ;
                        end
                     end
                     OP_SEARCH: begin
                        if (is_empty) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff <= '{value: '0, position: '0, status: ST_NOT_FOUND,
                                       occupancy: 5'(count_ff)};
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           key_ff     <= wr_value;
                           rd_slot_ff <= front_ff;
                           cmp_off_ff <= '0;
                           state_ff   <= S_SCAN;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff <= '{value: '0, position: '0, status: ST_OK,
                                    occupancy: 5'(count_ff)};
                     end
                  endcase
               end
            end
            S_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff <= '{value: rd_ext[31:0], position: '0, status: ST_OK,
                           occupancy: 5'(count_ff)};
               state_ff <= S_IDLE;
            end
            S_SCAN: begin
               // rdata_ff holds the entry at offset cmp_off_ff; next read already issued
               rd_slot_ff <= next_slot;
               if (rdata_ff == key_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{value: '0, position: 4'(cmp_off_ff), status: ST_OK,
                              occupancy: 5'(count_ff)};
                  state_ff <= S_IDLE;
               end else if (cmp_off_ff == IW'(count_ff - 1'b1)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff <= '{value: '0, position: '0, status: ST_NOT_FOUND,
                              occupancy: 5'(count_ff)};
                  state_ff <= S_IDLE;
               end else begin
                  cmp_off_ff <= cmp_off_ff + 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CW'(cmp_off_ff) < count_ff))
      else $error("search walked past the stored entries");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_FULL) |-> (rsp_ff.occupancy == 5'(DEPTH)))
      else $error("full status reported below depth");

   a_take_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd_take && cmd.op == OP_SEARCH && !is_empty) |=> !rsp_valid_ff)
      else $error("search started while a result was still held");

endmodule

`default_nettype wire

// ===== hw/rtl/circular_deque_with_search.sv =====
// Top level of the circular deque with search: front decode/queue and execution side.
//
//   channel | direction | handshake          | beat fields
//   req_    | in        | req_valid/req_stall | action, value
//   rsp_    | out       | rsp_valid/rsp_stall | value_out, position, status, occupancy
//
// A beat waits in the command queue until the execution side takes it. Inserts,
// refusals and unused codes answer from idle, a remove goes through a read state,
// a search walks from the front to a match or the last entry; the single read
// port of the entry memory sets the one-entry-per-cycle search walk.
// Reset clears front, count and the queue at once; the entry memory is not cleared.
// The queue keeps taking beats, until it is full, while a result sits stalled in the output register.
`default_nettype none

module circular_deque_with_search import cdq_pkg::*; #(
   parameter int DEPTH      = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_value_out,
   output logic [3:0]       rsp_position,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_occupancy
);

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;
   rsp_type rsp;

   cdq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .req_value  (req_value),
      .cmd_valid  (cmd_valid),
      .cmd_take   (cmd_take),
      .cmd        (cmd)
   );

   cdq_back #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_value_out = rsp.value;
   assign rsp_position  = rsp.position;
   assign rsp_status    = rsp.status;
   assign rsp_occupancy = rsp.occupancy;

endmodule

`default_nettype wire
